[hw/rtl/sint_pkg.sv]
`timescale 1ns / 1ps

package sint_pkg;

    // Field widths of the request and result items
    localparam int VAL_W = 24;
    localparam int CNT_W = 11;

    // Defaults and limits
    localparam int SINT_FRAC_BITS = 16;
    localparam int MAX_INTERVALS  = 1024;

    // Saturation bounds, as magnitudes
    localparam logic [VAL_W-1:0] VAL_POS_MAX = 24'h7FFFFF;
    localparam logic [VAL_W-1:0] VAL_NEG_MAG = 24'h800000;

    // Divisor of the final h/3 scaling
    localparam logic [1:0] THIRD_DIVISOR = 2'd3;

    typedef struct packed {
        logic signed [VAL_W-1:0] lower_limit;
        logic signed [VAL_W-1:0] upper_limit;
        logic        [CNT_W-1:0] intervals;
    } sint_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] integral;
        logic                    bad_count;
    } sint_out_t;

endpackage

[hw/rtl/sint_mul_serial.sv]
`timescale 1ns / 1ps

// Shift-add multiplier, one multiplier bit per cycle, MSB first.
module sint_mul_serial #(
    parameter int A_W = 24,
    parameter int B_W = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [A_W-1:0]     mcand,
    input  logic [B_W-1:0]     mplier,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);

    localparam int P_W  = A_W + B_W;
    localparam int CN_W = $clog2(B_W + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CN_W-1:0] cnt_reg, cnt_next;
    logic [P_W-1:0]  acc_reg, acc_next;
    logic [A_W-1:0]  mcand_reg, mcand_next;
    logic [B_W-1:0]  mplier_reg, mplier_next;

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start) begin
            busy_next   = 1'b1;
            cnt_next    = CN_W'(B_W);
            acc_next    = '0;
            mcand_next  = mcand;
            mplier_next = mplier;
        end else if (busy_reg) begin
            acc_next    = {acc_reg[P_W-2:0], 1'b0}
                        + (mplier_reg[B_W-1] ? P_W'(mcand_reg) : '0);
            mplier_next = mplier_reg << 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == CN_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[hw/rtl/sint_div_serial.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. rem_init must be below divisor.
module sint_div_serial #(
    parameter int DVD_W = 24,
    parameter int DVS_W = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    input  logic [DVS_W-1:0] rem_init,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CN_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CN_W-1:0]  cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   trial_sub;
    logic             fits;

    assign trial     = {rem_reg, quo_reg[DVD_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = (trial >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CN_W'(DVD_W);
            quo_next  = dividend;
            rem_next  = rem_init;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CN_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hw/rtl/simpson_integration_core.sv]
`timescale 1ns / 1ps
// Sequence: an accepted even count n gives the step h = (b - a) / n; each of the
//   n+1 samples is squared and inverted, then h/3 scales the weighted sum. A rejected
//   count goes straight to S_EMIT with its flag set. Throughput: one request at a time;
//   s_ready stays low from acceptance until the result is handed to the output register.
// Reset: aresetn is synchronous, active low; it clears the control registers, count,
//   step, index and sum to zero at once, no clearing pass; data registers are not reset.

module simpson_integration_core
    import sint_pkg::*;
#(
    parameter int FRAC_BITS = SINT_FRAC_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  sint_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output sint_out_t m_data
);

    // Derived widths
    localparam int F     = FRAC_BITS;
    localparam int SQ_W  = 2 * VAL_W - F;                  // x^2 >> F
    localparam int DEN_W = SQ_W + 1;                       // 2^F + sq
    localparam int NUM_W = ((2 * F > SQ_W) ? 2 * F : SQ_W) + 1;
    localparam int YQ_W  = F + 1;                          // 0 < y <= 2^F
    localparam int W_W   = F + 14;                         // 4 * 2^F * 2048 fits
    localparam int P_W   = W_W + VAL_W;                    // |h| * weighted sum
    localparam int D3_W  = P_W + 1 - F;                    // rounded sum >> F

    // Sequencer states
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
    localparam logic [ST_W-1:0] S_DIVH   = 4'd1;
    localparam logic [ST_W-1:0] S_SQ_GO  = 4'd2;
    localparam logic [ST_W-1:0] S_SQ     = 4'd3;
    localparam logic [ST_W-1:0] S_RCP    = 4'd4;
    localparam logic [ST_W-1:0] S_SCL_GO = 4'd5;
    localparam logic [ST_W-1:0] S_SCL    = 4'd6;
    localparam logic [ST_W-1:0] S_DIV3   = 4'd7;
    localparam logic [ST_W-1:0] S_EMIT   = 4'd8;

    logic [ST_W-1:0]  state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [VAL_W-1:0] x_reg, x_next;                       // current abscissa
    logic             h_neg_reg, h_neg_next;
    logic [VAL_W-1:0] step_width_reg, step_width_next;     // signed h
    logic [CNT_W-1:0] sample_index_reg, sample_index_next;
    logic [W_W-1:0]   weighted_sum_reg, weighted_sum_next;
    sint_out_t        pend_reg, pend_next;
    sint_out_t        m_data_reg, m_data_next;
    logic             m_valid_reg, m_valid_next;

    logic             accept;
    logic             in_bad;
    logic [VAL_W:0]   diff;
    logic [VAL_W:0]   diff_abs;

    // Step division: |b - a| / n
    logic             divh_start, divh_done;
    logic [VAL_W-1:0] divh_quo;

    // Sample: square, then reciprocal
    logic [VAL_W-1:0]   x_abs;
    logic               sq_start, sq_done;
    logic [2*VAL_W-1:0] sq_prod;
    logic [DEN_W-1:0]   den;
    logic [NUM_W-1:0]   num;
    logic               divy_start, divy_done;
    logic [YQ_W-1:0]    y_quo;

    // Weighting
    logic             is_end;
    logic [W_W-1:0]   y_ext;
    logic [W_W-1:0]   w_add;

    // Final scaling
    logic [VAL_W-1:0] h_mag;
    logic             sc_start, sc_done;
    logic [P_W-1:0]   sc_prod;
    logic [P_W:0]     rnd_sum;
    logic             div3_start, div3_done;
    logic [D3_W-1:0]  q3;
    logic             pos_over, neg_over;
    logic [VAL_W-1:0] res;

    // ------------------------------------------------------------------
    // Request side: accept only while idle; the output register stands
    // between the sequencer and the result channel.
    // ------------------------------------------------------------------
    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    // Reject zero, odd, or too-large counts
    assign in_bad = (s_data.intervals == '0) || s_data.intervals[0]
                 || (32'(s_data.intervals) > 32'(MAX_INTERVALS));

    // b - a in one extra bit, then its magnitude (always below 2^VAL_W)
    assign diff     = {s_data.upper_limit[VAL_W-1], s_data.upper_limit}
                    - {s_data.lower_limit[VAL_W-1], s_data.lower_limit};
    assign diff_abs = diff[VAL_W] ? (~diff + 1'b1) : diff;

    assign divh_start = accept && !in_bad;

    sint_div_serial #(
        .DVD_W (VAL_W),
        .DVS_W (CNT_W)
    ) u_div_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (divh_start),
        .dividend (diff_abs[VAL_W-1:0]),
        .divisor  (s_data.intervals),
        .rem_init ('0),
        .done     (divh_done),
        .quotient (divh_quo)
    );

    // ------------------------------------------------------------------
    // Per sample: sq = |x|^2 >> F, y = round(2^2F / (2^F + sq)).
    // The quotient is known to fit in F+1 bits, so the top of the
    // numerator seeds the remainder and only F+1 steps remain.
    // ------------------------------------------------------------------
    assign x_abs    = x_reg[VAL_W-1] ? (~x_reg + 1'b1) : x_reg;
    assign sq_start = (state_reg == S_SQ_GO);

    sint_mul_serial #(
        .A_W (VAL_W),
        .B_W (VAL_W)
    ) u_mul_square (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .mcand   (x_abs),
        .mplier  (x_abs),
        .done    (sq_done),
        .product (sq_prod)
    );

    assign den = DEN_W'(sq_prod[2*VAL_W-1:F]) + (DEN_W'(1) << F);
    assign num = (NUM_W'(1) << (2 * F)) + NUM_W'(den >> 1);

    assign divy_start = (state_reg == S_SQ) && sq_done;

    sint_div_serial #(
        .DVD_W (YQ_W),
        .DVS_W (DEN_W)
    ) u_div_recip (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (divy_start),
        .dividend (num[F:0]),
        .divisor  (den),
        .rem_init (DEN_W'(num >> (F + 1))),
        .done     (divy_done),
        .quotient (y_quo)
    );

    // Simpson weights: ends 1, odd interior 4, even interior 2
    assign is_end = (sample_index_reg == '0) || (sample_index_reg == n_reg);
    assign y_ext  = W_W'(y_quo);
    assign w_add  = is_end ? y_ext
                  : (sample_index_reg[0] ? (y_ext << 2) : (y_ext << 1));

    // ------------------------------------------------------------------
    // Scaling: sign(h) * round(|h| * w / (3 * 2^F)), half away from zero.
    // Add 1.5 * 2^F, drop F bits by shift, then divide by three serially.
    // ------------------------------------------------------------------
    assign h_mag    = step_width_reg[VAL_W-1] ? (~step_width_reg + 1'b1) : step_width_reg;
    assign sc_start = (state_reg == S_SCL_GO);

    sint_mul_serial #(
        .A_W (W_W),
        .B_W (VAL_W)
    ) u_mul_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sc_start),
        .mcand   (weighted_sum_reg),
        .mplier  (h_mag),
        .done    (sc_done),
        .product (sc_prod)
    );

    assign rnd_sum    = {1'b0, sc_prod} + ((P_W + 1)'(3) << (F - 1));
    assign div3_start = (state_reg == S_SCL) && sc_done;

    sint_div_serial #(
        .DVD_W (D3_W),
        .DVS_W (2)
    ) u_div_third (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div3_start),
        .dividend (rnd_sum[P_W:F]),
        .divisor  (THIRD_DIVISOR),
        .rem_init ('0),
        .done     (div3_done),
        .quotient (q3)
    );

    // Saturate to the signed result range
    assign pos_over = (q3 > D3_W'(VAL_POS_MAX));
    assign neg_over = (q3 > D3_W'(VAL_NEG_MAG));
    assign res = h_neg_reg ? (neg_over ? VAL_NEG_MAG : (~q3[VAL_W-1:0] + 1'b1))
                           : (pos_over ? VAL_POS_MAX : q3[VAL_W-1:0]);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next        = state_reg;
        n_next            = n_reg;
        x_next            = x_reg;
        h_neg_next        = h_neg_reg;
        step_width_next   = step_width_reg;
        sample_index_next = sample_index_reg;
        weighted_sum_next = weighted_sum_reg;
        pend_next         = pend_reg;
        m_data_next       = m_data_reg;
        // drop the result once taken
        m_valid_next      = m_valid_reg && !m_ready;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    n_next            = s_data.intervals;
                    x_next            = s_data.lower_limit;
                    h_neg_next        = diff[VAL_W];
                    sample_index_next = '0;
                    weighted_sum_next = '0;
                    if (in_bad) begin
                        // reject: zero result, flag set, state cleared
                        step_width_next    = '0;
                        pend_next.integral = '0;
                        pend_next.bad_count = 1'b1;
                        state_next         = S_EMIT;
                    end else begin
                        state_next = S_DIVH;
                    end
                end
            end
            S_DIVH: begin
                if (divh_done) begin
                    step_width_next = h_neg_reg ? (~divh_quo + 1'b1) : divh_quo;
                    state_next      = S_SQ_GO;
                end
            end
            S_SQ_GO: begin
                state_next = S_SQ;
            end
            S_SQ: begin
                if (sq_done) begin
                    state_next = S_RCP;
                end
            end
            S_RCP: begin
                if (divy_done) begin
                    // accumulate, advance the abscissa
                    weighted_sum_next = weighted_sum_reg + w_add;
                    x_next            = x_reg + step_width_reg;
                    if (sample_index_reg == n_reg) begin
                        state_next = S_SCL_GO;
                    end else begin
                        sample_index_next = sample_index_reg + 1'b1;
                        state_next        = S_SQ_GO;
                    end
                end
            end
            S_SCL_GO: begin
                state_next = S_SCL;
            end
            S_SCL: begin
                if (sc_done) begin
                    state_next = S_DIV3;
                end
            end
            S_DIV3: begin
                if (div3_done) begin
                    pend_next.integral  = res;
                    pend_next.bad_count = 1'b0;
                    state_next          = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = pend_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            m_valid_reg      <= 1'b0;
            n_reg            <= '0;
            step_width_reg   <= '0;
            sample_index_reg <= '0;
            weighted_sum_reg <= '0;
        end else begin
            state_reg        <= state_next;
            m_valid_reg      <= m_valid_next;
            n_reg            <= n_next;
            step_width_reg   <= step_width_next;
            sample_index_reg <= sample_index_next;
            weighted_sum_reg <= weighted_sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        h_neg_reg  <= h_neg_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_units_one_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({divh_done, sq_done, divy_done, sc_done, div3_done}))
        else $error("more than one arithmetic unit finished in the same cycle");

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sample_index_reg <= n_reg)
        else $error("sample index ran past the interval count");

    a_recip_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RCP && divy_done)
            |-> (y_quo != '0 && y_quo <= (YQ_W'(1) << F)))
        else $error("reciprocal sample out of range");

    a_emit_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && m_valid_reg && !m_ready)
            |=> (state_reg == S_EMIT && m_valid_reg))
        else $error("result overwrote an untaken result");

endmodule
